// File: sv/rasmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rasmr_pkg
// Shared types and codes for the rational add / subtract / multiply block.
// ----------------------------------------------------------------------------
package rasmr_pkg;

	localparam int NUM_W = 33;
	localparam int DEN_W = 31;

	// opcodes
	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;

	// multiplier steps
	localparam logic [1:0] MSTEP_P0  = 2'd0;
	localparam logic [1:0] MSTEP_P1  = 2'd1;
	localparam logic [1:0] MSTEP_DEN = 2'd2;

	// result selection
	localparam logic [1:0] OSEL_ZDEN = 2'd0;
	localparam logic [1:0] OSEL_ZNUM = 2'd1;
	localparam logic [1:0] OSEL_RES  = 2'd2;

	typedef struct packed {
		logic signed [NUM_W-1:0] result_num;
		logic [DEN_W-1:0]        result_den;
		logic                    div_zero;
	} rsp_t;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		logic [1:0] mstep;
		logic       add_en;
		logic       gcd_init;
		logic       gcd_step;
		logic       shl_step;
		logic       div_init;
		logic       div_src_den;
		logic       div_step;
		logic       out_load;
		logic [1:0] out_sel;
	} cmd_t;

	typedef struct packed {
		logic den_zero;
		logic num_zero;
		logic gcd_eq;
		logic k_zero;
	} sts_t;

endpackage

// File: sv/rasmr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rasmr_datapath
// Operand decode, shared multiplier, signed add, binary gcd and restoring
// divider, plus the result register.
// ----------------------------------------------------------------------------
module rasmr_datapath #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                     clk,
	input  logic [1:0]               opcode,
	input  logic [OPERAND_WIDTH-1:0] arg_one,
	input  logic [OPERAND_WIDTH-1:0] arg_two,
	input  logic [OPERAND_WIDTH-1:0] arg_three,
	input  logic [OPERAND_WIDTH-1:0] arg_four,
	input  rasmr_pkg::cmd_t          cmd,
	output rasmr_pkg::sts_t          sts,
	output rasmr_pkg::rsp_t          rsp
);
	import rasmr_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int MW = 2 * W;
	localparam int KW = $clog2(MW + 1);
	localparam int EW = (MW + 1 > NUM_W) ? MW + 1 : NUM_W;

	logic [1:0]    op_q;
	logic [W-1:0]  m1_q, m2_q, m3_q, m4_q;
	logic          s1_q, s2_q, s3_q, s4_q;
	logic [MW-1:0] p0_q, p1_q, p2_q;
	logic [MW-1:0] num_q, den_q;
	logic          neg_q;
	logic [MW-1:0] a_q, b_q;
	logic [KW-1:0] k_q;
	logic [MW-1:0] q_q, d_q, nq_q;
	logic [MW:0]   rem_q;
	rsp_t          rsp_q;

	logic [W-1:0]  mul_a, mul_b;
	logic [MW-1:0] prod;
	logic          is_mul, t0_neg, t1_neg, den_neg;
	logic [MW-1:0] sum_mag;
	logic          sum_neg;
	logic [MW:0]   div_sh, div_diff;
	logic          div_ge;
	logic [EW-1:0] n_ext, n_sgn, d_ext;

	assign is_mul = op_q[1];

	// multiplier operand selection
	always_comb begin
		mul_a = m2_q;
		mul_b = m4_q;
		case (cmd.mstep)
			MSTEP_P0: begin
				mul_a = m1_q;
				mul_b = is_mul ? m2_q : m4_q;
			end
			MSTEP_P1: begin
				mul_a = m3_q;
				mul_b = is_mul ? m4_q : m2_q;
			end
			default: begin
				mul_a = m2_q;
				mul_b = m4_q;
			end
		endcase
	end

	assign prod = MW'(mul_a) * MW'(mul_b);

	// product signs
	assign t0_neg  = s1_q ^ (is_mul ? s2_q : s4_q);
	assign t1_neg  = (s3_q ^ (is_mul ? s4_q : s2_q)) ^ (op_q == OP_SUB);
	assign den_neg = is_mul ? (s3_q ^ s4_q) : (s2_q ^ s4_q);

	// signed magnitude add of the two cross products
	always_comb begin
		if (t0_neg == t1_neg) begin
			sum_mag = p0_q + p1_q;
			sum_neg = t0_neg;
		end else if (p0_q >= p1_q) begin
			sum_mag = p0_q - p1_q;
			sum_neg = t0_neg;
		end else begin
			sum_mag = p1_q - p0_q;
			sum_neg = t1_neg;
		end
	end

	// restoring divider step
	assign div_sh   = {rem_q[MW-1:0], q_q[MW-1]};
	assign div_ge   = div_sh >= {1'b0, d_q};
	assign div_diff = div_sh - {1'b0, d_q};

	assign sts.den_zero = (den_q == '0);
	assign sts.num_zero = (num_q == '0);
	assign sts.gcd_eq   = (a_q == b_q) && a_q[0] && b_q[0];
	assign sts.k_zero   = (k_q == '0);

	// result formatting
	assign n_ext = EW'(nq_q);
	assign n_sgn = neg_q ? (~n_ext + EW'(1)) : n_ext;
	assign d_ext = EW'(q_q);

	always_ff @(posedge clk) begin
		// operand capture
		if (cmd.load) begin
			op_q <= opcode;
			s1_q <= arg_one[W-1];
			s2_q <= arg_two[W-1];
			s3_q <= arg_three[W-1];
			s4_q <= arg_four[W-1];
			m1_q <= arg_one[W-1]   ? (~arg_one + W'(1))   : arg_one;
			m2_q <= arg_two[W-1]   ? (~arg_two + W'(1))   : arg_two;
			m3_q <= arg_three[W-1] ? (~arg_three + W'(1)) : arg_three;
			m4_q <= arg_four[W-1]  ? (~arg_four + W'(1))  : arg_four;
		end
		// products
		if (cmd.mul_en) begin
			case (cmd.mstep)
				MSTEP_P0: p0_q <= prod;
				MSTEP_P1: p1_q <= prod;
				default:  p2_q <= prod;
			endcase
		end
		// numerator and denominator
		if (cmd.add_en) begin
			if (is_mul) begin
				num_q <= p0_q;
				den_q <= p1_q;
				neg_q <= t0_neg ^ den_neg;
			end else begin
				num_q <= sum_mag;
				den_q <= p2_q;
				neg_q <= sum_neg ^ den_neg;
			end
		end
		// binary gcd
		if (cmd.gcd_init) begin
			a_q <= num_q;
			b_q <= den_q;
			k_q <= '0;
		end else if (cmd.gcd_step) begin
			if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + KW'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q > b_q) begin
				a_q <= a_q - b_q;
			end else if (b_q > a_q) begin
				b_q <= b_q - a_q;
			end
		end else if (cmd.shl_step) begin
			a_q <= a_q << 1;
			k_q <= k_q - KW'(1);
		end
		// divider
		if (cmd.div_init) begin
			q_q   <= cmd.div_src_den ? den_q : num_q;
			rem_q <= '0;
			d_q   <= a_q;
			if (cmd.div_src_den) nq_q <= q_q;
		end else if (cmd.div_step) begin
			q_q   <= {q_q[MW-2:0], div_ge};
			rem_q <= div_ge ? div_diff : div_sh;
		end
		// result register
		if (cmd.out_load) begin
			case (cmd.out_sel)
				OSEL_ZDEN: begin
					rsp_q.result_num <= '0;
					rsp_q.result_den <= '0;
					rsp_q.div_zero   <= 1'b1;
				end
				OSEL_ZNUM: begin
					rsp_q.result_num <= '0;
					rsp_q.result_den <= DEN_W'(1);
					rsp_q.div_zero   <= 1'b0;
				end
				default: begin
					rsp_q.result_num <= n_sgn[NUM_W-1:0];
					rsp_q.result_den <= d_ext[DEN_W-1:0];
					rsp_q.div_zero   <= 1'b0;
				end
			endcase
		end
	end

	assign rsp = rsp_q;

endmodule

// File: sv/rasmr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rasmr_ctrl
// Sequencer: multiply steps, add, zero checks, gcd loop and shift-back, two
// divisions and the result handshake.
// ----------------------------------------------------------------------------
module rasmr_ctrl #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	input  rasmr_pkg::sts_t sts,
	output rasmr_pkg::cmd_t cmd
);
	import rasmr_pkg::*;

	localparam int MW = 2 * OPERAND_WIDTH;
	localparam int CW = $clog2(MW + 1);

	typedef enum logic [3:0] {
		ST_IDLE, ST_M0, ST_M1, ST_M2, ST_ADD, ST_CHK, ST_GCD, ST_SHL,
		ST_DIVN, ST_DINIT, ST_DIVD, ST_OUT
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    sel_q;
	logic          rsp_valid_q;
	logic          slot_free, cnt_last;

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign cnt_last  = (cnt_q == CW'(MW - 1));
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	// command decode
	always_comb begin
		cmd = '0;
		cmd.out_sel = sel_q;
		unique case (state_q)
			ST_IDLE:  cmd.load = req_valid;
			ST_M0: begin
				cmd.mul_en = 1'b1;
				cmd.mstep  = MSTEP_P0;
			end
			ST_M1: begin
				cmd.mul_en = 1'b1;
				cmd.mstep  = MSTEP_P1;
			end
			ST_M2: begin
				cmd.mul_en = 1'b1;
				cmd.mstep  = MSTEP_DEN;
			end
			ST_ADD:   cmd.add_en = 1'b1;
			ST_CHK:   cmd.gcd_init = !sts.den_zero && !sts.num_zero;
			ST_GCD:   cmd.gcd_step = !sts.gcd_eq;
			ST_SHL: begin
				cmd.shl_step = !sts.k_zero;
				cmd.div_init = sts.k_zero;
			end
			ST_DIVN:  cmd.div_step = 1'b1;
			ST_DINIT: begin
				cmd.div_init    = 1'b1;
				cmd.div_src_den = 1'b1;
			end
			ST_DIVD:  cmd.div_step = 1'b1;
			ST_OUT:   cmd.out_load = slot_free;
			default:  cmd = '0;
		endcase
	end

	// state, counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			sel_q       <= OSEL_RES;
			rsp_valid_q <= 1'b0;
		end else begin
			// result valid: set on a new result, cleared on a transfer
			if (state_q == ST_OUT && slot_free) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (req_valid) state_q <= ST_M0;
				ST_M0:   state_q <= ST_M1;
				ST_M1:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_ADD;
				ST_ADD:  state_q <= ST_CHK;
				ST_CHK: begin
					if (sts.den_zero) begin
						sel_q   <= OSEL_ZDEN;
						state_q <= ST_OUT;
					end else if (sts.num_zero) begin
						sel_q   <= OSEL_ZNUM;
						state_q <= ST_OUT;
					end else begin
						sel_q   <= OSEL_RES;
						state_q <= ST_GCD;
					end
				end
				ST_GCD: if (sts.gcd_eq) state_q <= ST_SHL;
				ST_SHL: begin
					if (sts.k_zero) begin
						cnt_q   <= '0;
						state_q <= ST_DIVN;
					end
				end
				ST_DIVN: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_last) state_q <= ST_DINIT;
				end
				ST_DINIT: begin
					cnt_q   <= '0;
					state_q <= ST_DIVD;
				end
				ST_DIVD: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_last) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (slot_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: sv/rational_add_sub_mul_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_add_sub_mul_reduce
// Rational add, subtract and multiply of four signed operands with the
// result reduced by the gcd of numerator and denominator.
// ----------------------------------------------------------------------------
// channel  handshake              payload
// req      req_valid / req_stall  opcode, arg_one .. arg_four
// rsp      rsp_valid / rsp_stall  rsp (result_num, result_den, div_zero)
//
// one item at a time: multiply steps, add, check, then a binary gcd loop
// and its shift-back, and two restoring divisions; zero cases skip gcd and
// division and go straight to the result.
// reset clears the sequencer and the result valid; no clearing pass.
// req_stall is high while an item is in work; a waiting result holds the
// sequencer only at the point where the next result is written.
// ----------------------------------------------------------------------------
module rational_add_sub_mul_reduce #(
	parameter int OPERAND_WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [1:0]               opcode,
	input  logic [OPERAND_WIDTH-1:0] arg_one,
	input  logic [OPERAND_WIDTH-1:0] arg_two,
	input  logic [OPERAND_WIDTH-1:0] arg_three,
	input  logic [OPERAND_WIDTH-1:0] arg_four,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output rasmr_pkg::rsp_t          rsp
);
	import rasmr_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	rasmr_ctrl #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// arithmetic
	rasmr_datapath #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_datapath (
		.clk       (clk),
		.opcode    (opcode),
		.arg_one   (arg_one),
		.arg_two   (arg_two),
		.arg_three (arg_three),
		.arg_four  (arg_four),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule

// File: test/rational_add_sub_mul_reduce_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_add_sub_mul_reduce_tb
// Drives operand sets through the rational block under several idle and stall
// patterns, predicts each reduced fraction and compares every result field.
// ----------------------------------------------------------------------------
module rational_add_sub_mul_reduce_tb;
	import rasmr_pkg::*;

	localparam int OW = 16;
	localparam longint CYCLE_LIMIT = 3000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic [1:0] opcode = OP_ADD;
	logic [OW-1:0] arg_one = '0;
	logic [OW-1:0] arg_two = '0;
	logic [OW-1:0] arg_three = '0;
	logic [OW-1:0] arg_four = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	rsp_t fraction_q[$];
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int mismatches = 0;
	longint cycles = 0;

	rational_add_sub_mul_reduce #(.OPERAND_WIDTH(OW)) dut (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.opcode(opcode), .arg_one(arg_one), .arg_two(arg_two),
		.arg_three(arg_three), .arg_four(arg_four),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #5 clk = ~clk;

	// reduced fraction from the operands, exact in 64-bit signed arithmetic
	function automatic rsp_t reduce_fraction(logic [1:0] op, logic [OW-1:0] a1,
			logic [OW-1:0] a2, logic [OW-1:0] a3, logic [OW-1:0] a4);
		rsp_t r;
		longint p, q, x, s, n, d, g, t, na, da;
		p = longint'(signed'(a1));
		q = longint'(signed'(a2));
		x = longint'(signed'(a3));
		s = longint'(signed'(a4));
		if (op[1]) begin
			n = p * q;
			d = x * s;
		end else begin
			n = (op == OP_SUB) ? p * s - x * q : p * s + x * q;
			d = q * s;
		end
		r = '0;
		if (d == 0) begin
			r.div_zero = 1'b1;
		end else if (n == 0) begin
			r.result_den = DEN_W'(1);
		end else begin
			na = (n < 0) ? -n : n;
			da = (d < 0) ? -d : d;
			g = na;
			t = da;
			while (t != 0) begin
				longint m;
				m = g % t;
				g = t;
				t = m;
			end
			na = na / g;
			da = da / g;
			r.result_num = NUM_W'(((n < 0) != (d < 0)) ? -na : na);
			r.result_den = DEN_W'(da);
		end
		return r;
	endfunction

	// cycle count and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[rational_add_sub_mul_reduce] ERROR");
			$finish;
		end
	end

	// receiver stall: random, or held for a long stretch
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (fraction_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result num=%0d den=%0d dz=%0b",
						rsp.result_num, rsp.result_den, rsp.div_zero);
			end else begin
				rsp_t e;
				e = fraction_q.pop_front();
				if (e.result_num !== rsp.result_num || e.result_den !== rsp.result_den
						|| e.div_zero !== rsp.div_zero) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %0d/%0d dz=%0b got %0d/%0d dz=%0b",
							e.result_num, e.result_den, e.div_zero,
							rsp.result_num, rsp.result_den, rsp.div_zero);
				end
			end
		end
	end

	// one transfer on the request channel, with random idle cycles before it
	task automatic send_item(logic [1:0] op, logic [OW-1:0] a1, logic [OW-1:0] a2,
			logic [OW-1:0] a3, logic [OW-1:0] a4);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		opcode <= op;
		arg_one <= a1;
		arg_two <= a2;
		arg_three <= a3;
		arg_four <= a4;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		fraction_q.push_back(reduce_fraction(op, a1, a2, a3, a4));
	endtask

	task automatic release_valid();
		req_valid <= 1'b0;
		@(posedge clk);
	endtask

	// random operand: half full range, the rest small or extreme values
	function automatic logic [OW-1:0] rand_arg();
		case ($urandom_range(5))
			0: return OW'($urandom_range(8)) - OW'(4);
			1: return {1'b1, {(OW-1){1'b0}}};
			2: return {1'b0, {(OW-1){1'b1}}};
			default: return OW'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		logic [OW-1:0] mn, mx;
		mn = {1'b1, {(OW-1){1'b0}}};
		mx = {1'b0, {(OW-1){1'b1}}};
		send_item(OP_ADD, 1, 2, 1, 3);
		send_item(OP_SUB, 1, 2, 1, 2);
		send_item(OP_MUL, 2, 3, 4, 6);
		send_item(2'd3, 5, 7, 3, 2);
		send_item(OP_ADD, 1, 0, 1, 1);
		send_item(OP_MUL, 0, 0, 0, 5);
		send_item(OP_SUB, 0, 3, 0, 5);
		send_item(OP_MUL, 0, 4, 3, 5);
		send_item(OP_ADD, mn, mn, mn, mn);
		send_item(OP_SUB, mn, mx, mx, mn);
		send_item(OP_MUL, mn, mn, mx, mx);
		send_item(OP_MUL, mx, mx, mn, mn);
		send_item(OP_ADD, mx, mx, mx, mx);
		send_item(OP_SUB, mx, mn, mn, mx);
		send_item(OP_ADD, -16'sd3, 4, 5, -16'sd6);
		send_item(OP_MUL, mn, 1, 1, mx);
		send_item(2'd3, mn, mn, 1, 1);
		send_item(OP_SUB, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
		release_valid();
	endtask

	task automatic test_random(int n, int idle, int stall);
		idle_pct = idle;
		stall_pct = stall;
		repeat (n) send_item(2'($urandom_range(3)), rand_arg(), rand_arg(),
			rand_arg(), rand_arg());
		release_valid();
	endtask

	// receiver holds off long while items keep coming
	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 2000;
		repeat (20) send_item(2'($urandom_range(3)), rand_arg(), rand_arg(),
			rand_arg(), rand_arg());
		release_valid();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(500, 0, 0);
		test_random(400, 72, 0);
		test_random(400, 0, 72);
		test_random(500, 12, 12);
		test_backpressure();
		test_random(200, 0, 0);
		while (fraction_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && fraction_q.size() == 0)
			$display("[rational_add_sub_mul_reduce] OK");
		else
			$display("[rational_add_sub_mul_reduce] ERROR");
		$finish;
	end

endmodule
